// ===== hdl/h2r_pkg.sv =====
// Shared types, constants and hue helpers for the HSL to RGB converter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package h2r_pkg;

  // Fixed field widths
  localparam int HUE_W  = 9;
  localparam int CHAN_W = 8;
  localparam int WT_W   = 6;
  localparam int N_CHAN = 3;

  // Angles in whole degrees
  localparam logic [HUE_W-1:0] FULL_CIRCLE   = 9'd360;
  localparam logic [HUE_W-1:0] THIRD_CIRCLE  = 9'd120;
  localparam logic [HUE_W-1:0] TWO_THIRDS    = 9'd240;
  localparam logic [HUE_W-1:0] SIXTH_CIRCLE  = 9'd60;
  localparam logic [HUE_W-1:0] HOLD_END      = 9'd180;

  // Full ramp weight (the flat top of the ramp)
  localparam logic [WT_W-1:0] WT_FULL = 6'd60;

  // Lane order
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  // Ramp weight, 0..60, applied to the level difference
  typedef logic [WT_W-1:0] h2r_wt_t;

  // Wrap a sum of two angles below 360 back into [0, 360)
  function automatic logic [HUE_W-1:0] hue_wrap(input logic [HUE_W:0] x);
    logic [HUE_W:0] r;
    r = (x >= {1'b0, FULL_CIRCLE}) ? x - {1'b0, FULL_CIRCLE} : x;
    return r[HUE_W-1:0];
  endfunction

  // Piecewise hue ramp: rise over 0..60, hold to 180, fall to 240, then zero
  function automatic h2r_wt_t ramp_weight(input logic [HUE_W-1:0] x);
    logic [HUE_W-1:0] d;
    h2r_wt_t          w;
    d = TWO_THIRDS - x;
    if (x < SIXTH_CIRCLE) begin
      w = x[WT_W-1:0];
    end else if (x < HOLD_END) begin
      w = WT_FULL;
    end else if (x < TWO_THIRDS) begin
      w = d[WT_W-1:0];
    end else begin
      w = '0;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/h2r_front.sv =====
// Input stages: hue reduction and range clamp, then the l*s product and hue weights.
// Depends on h2r_pkg.
`default_nettype none

module h2r_front import h2r_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     valid_i,
  input  wire logic [HUE_W-1:0]         hue_i,
  input  wire logic [FRAC_BITS:0]       sat_i,
  input  wire logic [FRAC_BITS:0]       light_i,
  output logic                          valid_o,
  output logic [2*FRAC_BITS:0]          prod_o,
  output logic [FRAC_BITS:0]            sat_o,
  output logic [FRAC_BITS:0]            light_o,
  output logic                          low_half_o,
  output h2r_wt_t [N_CHAN-1:0]          wt_o
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                  v1_r;
  logic [HUE_W-1:0]      hue1_r, hue1_nxt;
  logic [FRAC_BITS:0]    sat1_r, sat1_nxt;
  logic [FRAC_BITS:0]    light1_r, light1_nxt;

  logic                  v2_r;
  logic [2*FRAC_BITS:0]  prod2_r;
  logic [FRAC_BITS:0]    sat2_r, light2_r;
  logic                  low2_r, low2_nxt;
  h2r_wt_t [N_CHAN-1:0]  wt2_r, wt2_nxt;

  logic [2*FRAC_BITS+1:0] prod_full;
  logic [HUE_W-1:0]       ang_red, ang_blue;

  // Stage 1: reduce hue into one turn, saturate s and l at 1.0
  always_comb begin
    hue1_nxt   = (hue_i >= FULL_CIRCLE) ? hue_i - FULL_CIRCLE : hue_i;
    sat1_nxt   = (sat_i > ONE) ? ONE : sat_i;
    light1_nxt = (light_i > ONE) ? ONE : light_i;
  end

  // Stage 2: product l*s, lower-half flag, per-channel ramp weights
  always_comb begin
    prod_full = (2*FRAC_BITS+2)'(light1_r) * (2*FRAC_BITS+2)'(sat1_r);
    low2_nxt  = !light1_r[FRAC_BITS] && !light1_r[FRAC_BITS-1];
    ang_red   = hue_wrap({1'b0, hue1_r} + {1'b0, THIRD_CIRCLE});
    ang_blue  = hue_wrap({1'b0, hue1_r} + {1'b0, TWO_THIRDS});
    wt2_nxt[LANE_RED]   = ramp_weight(ang_red);
    wt2_nxt[LANE_GREEN] = ramp_weight(hue1_r);
    wt2_nxt[LANE_BLUE]  = ramp_weight(ang_blue);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    hue1_r   <= hue1_nxt;
    sat1_r   <= sat1_nxt;
    light1_r <= light1_nxt;
    prod2_r  <= prod_full[2*FRAC_BITS:0];
    sat2_r   <= sat1_r;
    light2_r <= light1_r;
    low2_r   <= low2_nxt;
    wt2_r    <= wt2_nxt;
  end

  assign valid_o    = v2_r;
  assign prod_o     = prod2_r;
  assign sat_o      = sat2_r;
  assign light_o    = light2_r;
  assign low_half_o = low2_r;
  assign wt_o       = wt2_r;

endmodule

`default_nettype wire

// ===== hdl/h2r_levels.sv =====
// Level stage: forms the low level v1 and half the level span (v2 - v1) / 2.
// Depends on h2r_pkg.
`default_nettype none

module h2r_levels import h2r_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     valid_i,
  input  wire logic [2*FRAC_BITS:0]     prod_i,
  input  wire logic [FRAC_BITS:0]       sat_i,
  input  wire logic [FRAC_BITS:0]       light_i,
  input  wire logic                     low_half_i,
  input  wire h2r_wt_t [N_CHAN-1:0]     wt_i,
  output logic                          valid_o,
  output logic [2*FRAC_BITS:0]          lo_o,
  output logic [2*FRAC_BITS:0]          span_o,
  output h2r_wt_t [N_CHAN-1:0]          wt_o
);

  logic                  valid_r;
  logic [2*FRAC_BITS:0]  lo_r, lo_nxt;
  logic [2*FRAC_BITS:0]  span_r, span_nxt;
  h2r_wt_t [N_CHAN-1:0]  wt_r;

  logic [2*FRAC_BITS:0]  sat_scaled, light_scaled;

  // v2 - l is l*s below one half and s*(1 - l) above; v1 = l - that
  always_comb begin
    sat_scaled   = {sat_i, {FRAC_BITS{1'b0}}};
    light_scaled = {light_i, {FRAC_BITS{1'b0}}};
    span_nxt     = low_half_i ? prod_i : sat_scaled - prod_i;
    lo_nxt       = light_scaled - span_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    span_r <= span_nxt;
    wt_r   <= wt_i;
  end

  assign valid_o = valid_r;
  assign lo_o    = lo_r;
  assign span_o  = span_r;
  assign wt_o    = wt_r;

endmodule

`default_nettype wire

// ===== hdl/h2r_ramp.sv =====
// Ramp stages for all three lanes: numerator lo*60 + span*2w, then scale by 255/60.
// Depends on h2r_pkg.
`default_nettype none

module h2r_ramp import h2r_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     valid_i,
  input  wire logic [2*FRAC_BITS:0]     lo_i,
  input  wire logic [2*FRAC_BITS:0]     span_i,
  input  wire h2r_wt_t [N_CHAN-1:0]     wt_i,
  output logic                          valid_o,
  output logic [N_CHAN-1:0][CHAN_W-1:0] chan_o
);

  localparam int NUM_W = 2*FRAC_BITS + 7;
  localparam int SC_W  = NUM_W + 4;
  localparam int SH    = 2*FRAC_BITS + 2;

  logic                          v4_r, v5_r;
  logic [NUM_W-1:0]              num_r   [N_CHAN];
  logic [NUM_W-1:0]              num_nxt [N_CHAN];
  logic [N_CHAN-1:0][CHAN_W-1:0] chan_r, chan_nxt;

  logic [NUM_W-1:0]              lo_part;
  logic [SC_W-1:0]               scaled  [N_CHAN];

  // Stage 4: numerator over a denominator of 60 * ONE^2
  always_comb begin
    lo_part = NUM_W'(lo_i) * NUM_W'(SIXTH_CIRCLE);
    for (int i = 0; i < N_CHAN; i++) begin
      num_nxt[i] = lo_part + NUM_W'(span_i) * NUM_W'({wt_i[i], 1'b0});
    end
  end

  // Stage 5: 255/60 = 17/4, so the channel is (17 * num) >> (2F + 2)
  always_comb begin
    for (int i = 0; i < N_CHAN; i++) begin
      scaled[i]   = {num_r[i], 4'b0000} + SC_W'(num_r[i]);
      chan_nxt[i] = scaled[i][SH+CHAN_W-1:SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= valid_i;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    chan_r <= chan_nxt;
  end

  assign valid_o = v5_r;
  assign chan_o  = chan_r;

endmodule

`default_nettype wire

// ===== hdl/hsl_to_rgb_converter_top.sv =====
// HSL to RGB converter: five-stage pipeline from start to out_valid.
// Throughput one item per clock; busy stays low, the pipeline never holds back.
// Each item's result shows for exactly one cycle on out_* with out_valid high.
// Synchronous active-low reset clears the valid bits of all five stages.
// Depends on h2r_pkg, h2r_front, h2r_levels and h2r_ramp.
`default_nettype none

module hsl_to_rgb_converter_top import h2r_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [HUE_W-1:0]     in_hue_degrees,
  input  wire logic [FRAC_BITS:0]   in_saturation,
  input  wire logic [FRAC_BITS:0]   in_lightness,
  output logic                      out_valid,
  output logic [CHAN_W-1:0]         out_red,
  output logic [CHAN_W-1:0]         out_green,
  output logic [CHAN_W-1:0]         out_blue
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                          accept;
  logic                          f_valid, l_valid;
  logic [2*FRAC_BITS:0]          f_prod;
  logic [FRAC_BITS:0]            f_sat, f_light;
  logic                          f_low;
  h2r_wt_t [N_CHAN-1:0]          f_wt, l_wt;
  logic [2*FRAC_BITS:0]          l_lo, l_span;
  logic [N_CHAN-1:0][CHAN_W-1:0] chan;

  // Take an item every cycle that start is high
  assign busy   = 1'b0;
  assign accept = start && !busy;

  h2r_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (accept),
    .hue_i      (in_hue_degrees),
    .sat_i      (in_saturation),
    .light_i    (in_lightness),
    .valid_o    (f_valid),
    .prod_o     (f_prod),
    .sat_o      (f_sat),
    .light_o    (f_light),
    .low_half_o (f_low),
    .wt_o       (f_wt)
  );

  h2r_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (f_valid),
    .prod_i     (f_prod),
    .sat_i      (f_sat),
    .light_i    (f_light),
    .low_half_i (f_low),
    .wt_i       (f_wt),
    .valid_o    (l_valid),
    .lo_o       (l_lo),
    .span_o     (l_span),
    .wt_o       (l_wt)
  );

  h2r_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (l_valid),
    .lo_i    (l_lo),
    .span_i  (l_span),
    .wt_i    (l_wt),
    .valid_o (out_valid),
    .chan_o  (chan)
  );

  assign out_red   = chan[LANE_RED];
  assign out_green = chan[LANE_GREEN];
  assign out_blue  = chan[LANE_BLUE];

  // Each accepted item comes out on out_valid once it has passed the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5)) |-> (out_valid == $past(accept, 5)))
    else $error("out_valid does not follow an accepted item by five cycles");

  // Zero saturation gives a gray pixel
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_saturation, 5) == '0)) |->
    ((out_red == out_green) && (out_green == out_blue)))
    else $error("zero saturation did not give equal channels");

  // Full lightness gives white
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_lightness, 5) >= ONE)) |->
    ((out_red == '1) && (out_green == '1) && (out_blue == '1)))
    else $error("full lightness did not give white");

  // Zero lightness gives black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_lightness, 5) == '0)) |->
    ((out_red == '0) && (out_green == '0) && (out_blue == '0)))
    else $error("zero lightness did not give black");

endmodule

`default_nettype wire

// ===== bench/tb_hsl_to_rgb_converter_top.sv =====
// Self-checking bench for the HSL to RGB converter: a directed table, then random pixels,
// each result checked against the row's known colour or an integer-exact conversion written here.
// Depends on h2r_pkg and hsl_to_rgb_converter_top.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter_top;
  import h2r_pkg::*;

  localparam int FRAC_BITS    = 12;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 22;
  localparam int N_RANDOM     = 1600;
  localparam bit [63:0] ONE_FX = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_rgb_t;

  // One directed pixel; rgb is used only where known is set
  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [FRAC_BITS:0] sat;
    logic [FRAC_BITS:0] lit;
    bit                 known;
    pixel_rgb_t         rgb;
  } pixel_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [HUE_W-1:0]     in_hue_degrees = '0;
  logic [FRAC_BITS:0]   in_saturation = '0;
  logic [FRAC_BITS:0]   in_lightness = '0;
  logic                 out_valid;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;

  // Typed expectation that travels with the pixel on the input ports
  bit                   row_known = 1'b0;
  pixel_rgb_t           row_rgb = '0;

  pixel_rgb_t           pending_rgb[$];
  int                   mismatch_cnt = 0;
  int                   accepted_cnt = 0;
  int                   checked_cnt = 0;

  // Extremes, pure hues, wraps, saturation of both levels, ramp corners
  pixel_row_t directed_rows [N_DIRECTED] = '{
    '{9'd0,   13'd0,    13'd0,    1'b1, 24'h000000},
    '{9'd0,   13'd0,    13'd4096, 1'b1, 24'hFFFFFF},
    '{9'd200, 13'd0,    13'd2048, 1'b1, 24'h7F7F7F},
    '{9'd0,   13'd4096, 13'd2048, 1'b1, 24'hFF0000},
    '{9'd120, 13'd4096, 13'd2048, 1'b1, 24'h00FF00},
    '{9'd240, 13'd4096, 13'd2048, 1'b1, 24'h0000FF},
    '{9'd360, 13'd4096, 13'd2048, 1'b1, 24'hFF0000},
    '{9'd480, 13'd4096, 13'd2048, 1'b1, 24'h00FF00},
    '{9'd0,   13'd8191, 13'd2048, 1'b1, 24'hFF0000},
    '{9'd77,  13'd2000, 13'd8191, 1'b1, 24'hFFFFFF},
    '{9'd300, 13'd0,    13'd8191, 1'b1, 24'hFFFFFF},
    '{9'd511, 13'd4096, 13'd2048, 1'b0, 24'h000000},
    '{9'd59,  13'd3000, 13'd1000, 1'b0, 24'h000000},
    '{9'd60,  13'd3000, 13'd2047, 1'b0, 24'h000000},
    '{9'd179, 13'd1,    13'd2048, 1'b0, 24'h000000},
    '{9'd180, 13'd4095, 13'd2049, 1'b0, 24'h000000},
    '{9'd239, 13'd2048, 13'd1,    1'b0, 24'h000000},
    '{9'd359, 13'd4096, 13'd4095, 1'b0, 24'h000000},
    '{9'd30,  13'd1,    13'd1,    1'b0, 24'h000000},
    '{9'd90,  13'd8190, 13'd4097, 1'b0, 24'h000000},
    '{9'd150, 13'd6000, 13'd3000, 1'b0, 24'h000000},
    '{9'd256, 13'd2500, 13'd2048, 1'b0, 24'h000000}
  };

  hsl_to_rgb_converter_top #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue_degrees(in_hue_degrees),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // floor(255 * ramp(x)) with levels scaled by ONE squared, x in [0, 360)
  function automatic logic [CHAN_W-1:0] ramp_channel_level(input bit [63:0] lo,
                                                           input bit [63:0] hi,
                                                           input int unsigned x);
    bit [63:0] num;
    bit [63:0] den;
    den = 64'(SIXTH_CIRCLE) * ONE_FX * ONE_FX;
    if (x < SIXTH_CIRCLE) begin
      num = lo * 64'(SIXTH_CIRCLE) + (hi - lo) * 64'(x);
    end else if (x < HOLD_END) begin
      num = hi * 64'(SIXTH_CIRCLE);
    end else if (x < TWO_THIRDS) begin
      num = lo * 64'(SIXTH_CIRCLE) + (hi - lo) * 64'(240 - x);
    end else begin
      num = lo * 64'(SIXTH_CIRCLE);
    end
    num = (num * 64'd255) / den;
    return num[CHAN_W-1:0];
  endfunction

  // Exact HSL to RGB conversion of one pixel
  function automatic pixel_rgb_t convert_hsl(input logic [HUE_W-1:0] hue,
                                             input logic [FRAC_BITS:0] sat,
                                             input logic [FRAC_BITS:0] lit);
    int unsigned h;
    bit [63:0]   s;
    bit [63:0]   l;
    bit [63:0]   v1;
    bit [63:0]   v2;
    bit [63:0]   grey;
    pixel_rgb_t  px;
    h = hue % 360;
    s = 64'(sat);
    l = 64'(lit);
    if (s > ONE_FX) s = ONE_FX;
    if (l > ONE_FX) l = ONE_FX;
    // no saturation: plain grey at the lightness
    if (s == 0) begin
      grey = (l * 64'd255) >> FRAC_BITS;
      px.red   = grey[CHAN_W-1:0];
      px.green = grey[CHAN_W-1:0];
      px.blue  = grey[CHAN_W-1:0];
      return px;
    end
    if (2 * l < ONE_FX) begin
      v2 = l * (ONE_FX + s);
    end else begin
      v2 = (l + s) * ONE_FX - l * s;
    end
    v1 = 2 * l * ONE_FX - v2;
    px.red   = ramp_channel_level(v1, v2, (h + 120) % 360);
    px.green = ramp_channel_level(v1, v2, h);
    px.blue  = ramp_channel_level(v1, v2, (h + 240) % 360);
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Record accepted pixels and check every result against the oldest expectation
  always @(posedge clk) begin : check_results
    pixel_rgb_t want;
    if (rst_n && start && !busy) begin
      if (row_known) begin
        pending_rgb.push_back(row_rgb);
      end else begin
        pending_rgb.push_back(convert_hsl(in_hue_degrees, in_saturation, in_lightness));
      end
      accepted_cnt++;
    end
    if (rst_n && out_valid) begin
      checked_cnt++;
      if (pending_rgb.size() == 0) begin
        report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                  out_red, out_green, out_blue));
      end else begin
        want = pending_rgb.pop_front();
        if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue) begin
          report_mismatch($sformatf("expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                    want.red, want.green, want.blue,
                                    out_red, out_green, out_blue));
        end
      end
    end
  end

  // Present one pixel after a random idle stretch and hold it until taken
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [FRAC_BITS:0] sat,
                            input logic [FRAC_BITS:0] lit, input bit known,
                            input pixel_rgb_t rgb, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_hue_degrees <= hue;
    in_saturation  <= sat;
    in_lightness   <= lit;
    row_known      <= known;
    row_rgb        <= rgb;
    do @(posedge clk); while (busy);
  endtask

  // Draw a fraction value weighted toward zero, one, over-range and small values
  function automatic logic [FRAC_BITS:0] pick_fraction(input bit near_half);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return (FRAC_BITS+1)'(ONE_FX);
      2:       return (FRAC_BITS+1)'($urandom_range(4097, 8191));
      3:       return (FRAC_BITS+1)'($urandom_range(1, 15));
      4:       return near_half ? (FRAC_BITS+1)'($urandom_range(2040, 2056))
                                : (FRAC_BITS+1)'($urandom_range(4080, 4095));
      default: return (FRAC_BITS+1)'($urandom_range(0, 4096));
    endcase
  endfunction

  initial begin : stimulus
    int                 idle_pct;
    int                 guard;
    logic [HUE_W-1:0]   hue;
    // hold reset, then release on an edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].lit,
                 directed_rows[i].known, directed_rows[i].rgb, 32);
    end

    // random pixels in three idle phases: light gaps, heavy gaps, back to back
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_pct = (i < 540) ? 32 : (i < 1080) ? 75 : 0;
      hue = ($urandom_range(0, 99) < 85) ? HUE_W'($urandom_range(0, 359))
                                          : HUE_W'($urandom_range(360, 511));
      send_pixel(hue, pick_fraction(1'b0), pick_fraction(1'b1), 1'b0, '0, idle_pct);
    end
    start <= 1'b0;

    // drain the pipeline, then keep watching for stray results
    guard = 0;
    while (pending_rgb.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rgb.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", pending_rgb.size()));
    end

    $display("Converted %0d pixels (%0d directed, %0d random) under three idle patterns,",
             accepted_cnt, N_DIRECTED, N_RANDOM);
    $display("%0d results checked, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout: converter stopped making progress");
    $display("Mismatches found");
    $finish;
  end

endmodule
